FILE: hdl/sfd_pkg.sv
package sfd_pkg;

    localparam int ADDR_W = 10;
    localparam int BYTE_W = 8;

    // marker bytes
    localparam logic [BYTE_W-1:0] MARK_CR   = 8'd13;
    localparam logic [BYTE_W-1:0] MARK_LF   = 8'd10;
    localparam logic [BYTE_W-1:0] MARK_FAST = 8'd70;
    localparam logic [BYTE_W-1:0] MARK_SLOW = 8'd83;
    localparam logic [BYTE_W-1:0] MARK_END  = 8'd55;

    // channel spacing in the frame buffer for slow capture
    localparam logic [ADDR_W-1:0] CHAN_STRIDE = 10'd256;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ENDWAIT = 2'd2
    } phase_t;

    // one request between the classifier and the write stage
    typedef struct packed {
        logic              slow;
        logic              done;
        logic [ADDR_W-1:0] base;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
    } req_t;

    // queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: hdl/sfd_queue.sv
module sfd_queue
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  req_t      push_data,
    input  logic      pop,
    output req_t      pop_data,
    output q_status_t status
);

    req_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/sfd_front.sv
module sfd_front
    import sfd_pkg::*;
#(
    parameter int FRAME_GROUPS = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_bit,
    input  logic              accept,
    input  logic [BYTE_W-1:0] b0,
    input  logic [BYTE_W-1:0] b1,
    input  logic [BYTE_W-1:0] b2,
    output logic              push,
    output req_t              push_data
);

    localparam int CNT_W = ($clog2(FRAME_GROUPS) > 8) ? $clog2(FRAME_GROUPS) : 8;
    localparam logic [CNT_W-1:0] LAST_GROUP = CNT_W'(FRAME_GROUPS - 1);

    logic             slow_reg;
    logic             slow_next;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] slot_reg;
    logic [CNT_W-1:0] slot_next;

    logic              is_end;
    logic              is_start_slow;
    logic              is_start_fast;
    logic [ADDR_W-1:0] slot_a;
    logic [ADDR_W-1:0] fast_base;

    assign is_end        = (b0 == MARK_LF) && (b1 == MARK_CR) && (b2 == MARK_END);
    assign is_start_slow = (b0 == MARK_CR) && (b1 == MARK_LF) && (b2 == MARK_SLOW);
    assign is_start_fast = (b0 == MARK_CR) && (b1 == MARK_LF) && (b2 == MARK_FAST);

    // three bytes per group, wrapping at the buffer size
    assign slot_a    = ADDR_W'(slot_reg);
    assign fast_base = slot_a + {slot_a[ADDR_W-2:0], 1'b0};

    always_comb
    begin
        slow_next  = slow_reg;
        phase_next = phase_reg;
        slot_next  = slot_reg;
        if (cfg_write)
        begin
            slow_next = cfg_bit;
            if (cfg_bit != slow_reg)
            begin
                phase_next = PH_HUNT;
                slot_next  = '0;
            end
        end
        else if (accept)
        begin
            if (slow_reg)
            begin
                if (is_start_slow)
                begin
                    slot_next  = '0;
                    phase_next = PH_PAYLOAD;
                end
                else if (is_end)
                begin
                    slot_next = '0;
                end
                else if (phase_reg != PH_HUNT)
                begin
                    slot_next = CNT_W'(slot_reg[7:0] + 8'd1);
                end
            end
            else
            begin
                case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        if (slot_reg == LAST_GROUP)
                        begin
                            slot_next  = '0;
                            phase_next = PH_ENDWAIT;
                        end
                        else
                        begin
                            slot_next = slot_reg + CNT_W'(1);
                        end
                    end
                    PH_ENDWAIT:
                    begin
                        if (is_end)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        if (is_start_fast)
                        begin
                            phase_next = PH_PAYLOAD;
                            slot_next  = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        push           = 1'b0;
        push_data.slow = slow_reg;
        push_data.done = 1'b0;
        push_data.base = slow_reg ? ADDR_W'(slot_reg[7:0]) : fast_base;
        push_data.b0   = b0;
        push_data.b1   = b1;
        push_data.b2   = b2;
        if (accept && !cfg_write)
        begin
            if (slow_reg)
            begin
                push = !is_start_slow && !is_end && (phase_reg != PH_HUNT);
            end
            else if (phase_reg == PH_PAYLOAD)
            begin
                push           = 1'b1;
                push_data.done = (slot_reg == LAST_GROUP);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_reg  <= 1'b0;
            phase_reg <= PH_PAYLOAD;
            slot_reg  <= '0;
        end
        else
        begin
            slow_reg  <= slow_next;
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

FILE: hdl/sfd_back.sv
module sfd_back
    import sfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_status_t         q_status,
    input  req_t              q_data,
    output logic              pop,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [ADDR_W-1:0] addr_first,
    output logic [ADDR_W-1:0] addr_second,
    output logic [ADDR_W-1:0] addr_third,
    output logic [BYTE_W-1:0] data_first,
    output logic [BYTE_W-1:0] data_second,
    output logic [BYTE_W-1:0] data_third,
    output logic              frame_done
);

    logic              valid_reg;
    logic              valid_next;
    logic [ADDR_W-1:0] a0_reg;
    logic [ADDR_W-1:0] a1_reg;
    logic [ADDR_W-1:0] a2_reg;
    logic [ADDR_W-1:0] a1_next;
    logic [ADDR_W-1:0] a2_next;
    logic [BYTE_W-1:0] d0_reg;
    logic [BYTE_W-1:0] d1_reg;
    logic [BYTE_W-1:0] d2_reg;
    logic              done_reg;

    assign pop = !q_status.empty && (!valid_reg || !out_stall);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        // slow capture spreads the group over the three channels
        if (q_data.slow)
        begin
            a1_next = q_data.base + CHAN_STRIDE;
            a2_next = q_data.base + {CHAN_STRIDE[ADDR_W-2:0], 1'b0};
        end
        else
        begin
            a1_next = q_data.base + ADDR_W'(1);
            a2_next = q_data.base + ADDR_W'(2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a0_reg   <= q_data.base;
            a1_reg   <= a1_next;
            a2_reg   <= a2_next;
            d0_reg   <= q_data.b0;
            d1_reg   <= q_data.b1;
            d2_reg   <= q_data.b2;
            done_reg <= q_data.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign addr_first  = a0_reg;
    assign addr_second = a1_reg;
    assign addr_third  = a2_reg;
    assign data_first  = d0_reg;
    assign data_second = d1_reg;
    assign data_third  = d2_reg;
    assign frame_done  = done_reg;

endmodule

FILE: hdl/scope_frame_deframer_unit.sv
// path: a group that gives a buffer write passes through the request queue into the output
// register after it is taken; marker and idle groups give nothing
// throughput: one group per cycle while in_stall is low; a two-entry request queue sits in
// front of the output register, so in_stall rises only when it is full or while a mode
// write is offered
// reset (rst_n low, asynchronous): fast mode, payload phase, slot 0, queue empty, no output
module scope_frame_deframer_unit
    import sfd_pkg::*;
#(
    parameter int FRAME_GROUPS = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] byte_first,
    input  logic [BYTE_W-1:0] byte_second,
    input  logic [BYTE_W-1:0] byte_third,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] addr_first,
    output logic [ADDR_W-1:0] addr_second,
    output logic [ADDR_W-1:0] addr_third,
    output logic [BYTE_W-1:0] data_first,
    output logic [BYTE_W-1:0] data_second,
    output logic [BYTE_W-1:0] data_third,
    output logic              frame_done
);

    q_status_t q_status;
    req_t      push_data;
    req_t      pop_data;
    logic      push;
    logic      pop;
    logic      accept;

    assign cfg_ready = 1'b1;
    // a mode write holds the link side back for that cycle
    assign in_stall  = q_status.full || cfg_valid;
    assign accept    = in_valid && !in_stall;

    sfd_front #(
        .FRAME_GROUPS (FRAME_GROUPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_bit   (cfg_data),
        .accept    (accept),
        .b0        (byte_first),
        .b1        (byte_second),
        .b2        (byte_third),
        .push      (push),
        .push_data (push_data)
    );

    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    sfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_data      (pop_data),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .addr_first  (addr_first),
        .addr_second (addr_second),
        .addr_third  (addr_third),
        .data_first  (data_first),
        .data_second (data_second),
        .data_third  (data_third),
        .frame_done  (frame_done)
    );

endmodule

FILE: hdl/sfd_checker.sv
module sfd_checker
    import sfd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [ADDR_W-1:0] addr_first,
    input logic [ADDR_W-1:0] addr_second,
    input logic [ADDR_W-1:0] addr_third,
    input logic [BYTE_W-1:0] data_first,
    input logic [BYTE_W-1:0] data_second,
    input logic [BYTE_W-1:0] data_third,
    input logic              frame_done
);

    // a stalled request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(addr_first)
            && $stable(addr_second) && $stable(addr_third)
            && $stable(data_first) && $stable(data_second) && $stable(data_third)
            && $stable(frame_done))
        else $error("stalled output request changed");

    // either linear or channel-interleaved spacing
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (addr_second == ADDR_W'(addr_first + ADDR_W'(1))
                && addr_third == ADDR_W'(addr_first + ADDR_W'(2)))
            || (addr_second == ADDR_W'(addr_first + CHAN_STRIDE)
                && addr_third == ADDR_W'(addr_second + CHAN_STRIDE)))
        else $error("address spacing broken");

    // end of frame only in linear capture
    a_done_fast: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> addr_second == ADDR_W'(addr_first + ADDR_W'(1)))
        else $error("frame end flagged on interleaved write");

    // interleaved slot stays in the first channel
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && addr_second == ADDR_W'(addr_first + CHAN_STRIDE)
            |-> addr_first[ADDR_W-1:8] == '0)
        else $error("interleaved slot out of range");

endmodule

bind scope_frame_deframer_unit sfd_checker u_sfd_checker (.*);
